// ===== hdl/event_block_match_sad_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the event block matcher
// Expects clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef EVENT_BLOCK_MATCH_SAD_DEFINES_SVH
`define EVENT_BLOCK_MATCH_SAD_DEFINES_SVH

`ifndef ASSERT_OFF
`define EBMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EBMS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EBMS_ASSERT(label, prop, msg)
`define EBMS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== hdl/ebms_pkg.sv =====
// ----------------------------------------------------------------------------
// ebms_pkg
// Sizes, constants and per-column SAD helpers for the event block matcher.
// ----------------------------------------------------------------------------
package ebms_pkg;

    localparam int BLOCK      = 5;
    localparam int SEARCH     = 3;
    localparam int PIXEL_BITS = 4;

    localparam int FIELD_W = 44;
    localparam int NSHIFT  = 2 * SEARCH + 1;
    localparam int COLS    = BLOCK + 2 * SEARCH;
    localparam int CNT_W   = $clog2(COLS);
    localparam int IDX_W   = $clog2(NSHIFT);
    localparam int DIFF_W  = 5;
    localparam int SUM_W   = 16;
    localparam int SAD_W   = 15;
    localparam int OFS_W   = 3;
    localparam int FLOW_W  = 2 * OFS_W;

    localparam logic [SUM_W-1:0]  SUM_RESET     = 16'h7fff;
    localparam logic [SAD_W-1:0]  SAD_OUT_RESET = 15'h7fff;
    localparam logic [FLOW_W-1:0] FLOW_RESET    = 6'h3f;
    localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(COLS - 1);

    typedef logic [FIELD_W-1:0]           column_t;
    typedef logic [SUM_W-1:0]             sum_t;
    typedef logic [NSHIFT-1:0][SUM_W-1:0] sum_vec_t;

    // pixel l of a packed column; positions past the field read as zero
    function automatic logic [PIXEL_BITS-1:0] pixel_at(input column_t col, input int l);
        column_t sh;
        sh = col >> (PIXEL_BITS * l);
        return sh[PIXEL_BITS-1:0];
    endfunction

    // |a - b| kept as a 5-bit signed value
    function automatic logic [DIFF_W-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        logic [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        if (d[DIFF_W-1])
        begin
            d = DIFF_W'(0) - d;
        end
        return d;
    endfunction

    // column SAD of the centered reference pixels against the target at one shift
    function automatic sum_t column_sad(input column_t ref_col, input column_t tag_col,
                                        input int shift);
        sum_t              s;
        logic [DIFF_W-1:0] d;
        s = '0;
        for (int j = 0; j < BLOCK; j++)
        begin
            d = abs_diff(pixel_at(ref_col, j + SEARCH), pixel_at(tag_col, shift + j));
            s = s + {{(SUM_W-DIFF_W){d[DIFF_W-1]}}, d};
        end
        return s;
    endfunction

endpackage

// ===== hdl/ebms_col_if.sv =====
// ----------------------------------------------------------------------------
// ebms_col_if
// Column channel: one reference and one target column per transaction.
// ----------------------------------------------------------------------------
interface ebms_col_if import ebms_pkg::*; ();

    logic    valid;
    logic    ready;
    column_t ref_column;
    column_t tag_column;

    modport source (output valid, output ref_column, output tag_column, input ready);
    modport sink   (input valid, input ref_column, input tag_column, output ready);

endinterface

// ===== hdl/ebms_res_if.sv =====
// ----------------------------------------------------------------------------
// ebms_res_if
// Result channel: best SAD and flow code of one event per transaction.
// ----------------------------------------------------------------------------
interface ebms_res_if import ebms_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [SAD_W-1:0]  min_sad;
    logic [FLOW_W-1:0] flow_code;

    modport source (output valid, output min_sad, output flow_code, input ready);
    modport sink   (input valid, input min_sad, input flow_code, output ready);

endinterface

// ===== hdl/event_block_match_sad.sv =====
// ----------------------------------------------------------------------------
// event_block_match_sad - SAD block matching over one event's pixel columns
// columns: every transaction is one column pair; BLOCK+2*SEARCH columns make
//   an event, the first one starting a fresh search. There is no framing
//   signal, only reset realigns the column count.
// results: one transaction per event, after its last column, carrying the
//   smallest windowed SAD and its flow code (shift y in 5..3, offset x 2..0).
// Throughput: one column per cycle. Pipeline of five registers: input,
//   column SAD, window sums, window minimum, best/result register.
// results.valid rises once the last column has passed stages 1 to 4 and loads the result register.
// Stall: a result waiting in the output register does not block input;
//   columns.ready drops only when the next event's last column reaches stage 4
//   while the output register is still full and results.ready is low.
// Reset: column count, window sums and best match are cleared, no result.
// ----------------------------------------------------------------------------
`include "event_block_match_sad_defines.svh"

module event_block_match_sad import ebms_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    ebms_col_if.sink   columns,
    ebms_res_if.source results
);

    logic adv;

    // column counter
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // stage 1: input register
    logic             s1_valid_reg;
    column_t          s1_ref_reg;
    column_t          s1_tag_reg;
    logic [CNT_W-1:0] s1_pos_reg;

    // stage 2: column sums
    logic             s2_valid_reg;
    sum_vec_t         s2_colsum_reg;
    logic [CNT_W-1:0] s2_pos_reg;
    sum_vec_t         colsum;
    logic             s2_first;
    logic             s2_sub;

    // stage 3: window sums and history
    logic             s3_valid_reg;
    logic [CNT_W-1:0] s3_pos_reg;
    sum_vec_t         window_reg;
    sum_vec_t         window_next;
    sum_vec_t         hist_reg [BLOCK];

    // stage 4: window minimum
    logic             s4_valid_reg;
    logic [CNT_W-1:0] s4_pos_reg;
    sum_t             s4_min_reg;
    logic [IDX_W-1:0] s4_idx_reg;
    sum_t             min_val;
    logic [IDX_W-1:0] min_idx;
    logic             s4_first;
    logic             s4_upd;
    logic             s4_last;
    logic [OFS_W-1:0] s4_x;

    // stage 5: best match and result register
    sum_t              best_sum_reg;
    logic [FLOW_W-1:0] best_flow_reg;
    sum_t              best_base;
    logic [FLOW_W-1:0] flow_base;
    logic              take;
    sum_t              best_sum_next;
    logic [FLOW_W-1:0] best_flow_next;
    logic              push;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [SAD_W-1:0]  res_sad_reg;
    logic [FLOW_W-1:0] res_flow_reg;

    // the whole pipeline holds only when a result meets a full output register and results.ready is low
    assign adv = !(s4_valid_reg && s4_last && res_valid_reg && !results.ready);
    assign columns.ready = adv;

    assign cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (columns.valid && columns.ready)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= columns.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && columns.valid)
        begin
            s1_ref_reg <= columns.ref_column;
            s1_tag_reg <= columns.tag_column;
            s1_pos_reg <= cnt_reg;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        for (int i = 0; i < NSHIFT; i++)
        begin
            colsum[i] = column_sad(s1_ref_reg, s1_tag_reg, i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            s2_colsum_reg <= colsum;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    // ---------------- stage 3 ----------------
    assign s2_first = (s2_pos_reg == '0);
    // the column BLOCK steps back leaves the window from column BLOCK+1 on
    assign s2_sub   = (s2_pos_reg >= CNT_W'(BLOCK));

    always_comb
    begin
        for (int i = 0; i < NSHIFT; i++)
        begin
            window_next[i] = (s2_first ? '0 : window_reg[i]) + s2_colsum_reg[i]
                           - (s2_sub ? hist_reg[0][i] : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            s3_pos_reg <= s2_pos_reg;
            for (int j = 0; j < BLOCK - 1; j++)
            begin
                hist_reg[j] <= hist_reg[j+1];
            end
            hist_reg[BLOCK-1] <= s2_colsum_reg;
        end
    end

    // ---------------- stage 4 ----------------
    // first shift with the strictly smallest signed sum wins
    always_comb
    begin
        min_val = window_reg[0];
        min_idx = '0;
        for (int i = 1; i < NSHIFT; i++)
        begin
            if ($signed(window_reg[i]) < $signed(min_val))
            begin
                min_val = window_reg[i];
                min_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            s4_min_reg <= min_val;
            s4_idx_reg <= min_idx;
            s4_pos_reg <= s3_pos_reg;
        end
    end

    // ---------------- stage 5 ----------------
    assign s4_first = (s4_pos_reg == '0);
    assign s4_upd   = (s4_pos_reg >= CNT_W'(BLOCK - 1));
    assign s4_last  = (s4_pos_reg == CNT_LAST);
    assign s4_x     = OFS_W'({1'b0, s4_pos_reg} + (CNT_W+1)'(1) - (CNT_W+1)'(BLOCK));

    assign best_base = s4_first ? SUM_RESET : best_sum_reg;
    assign flow_base = s4_first ? FLOW_RESET : best_flow_reg;
    assign take      = s4_upd && ($signed(s4_min_reg) < $signed(best_base));

    assign best_sum_next  = take ? s4_min_reg : best_base;
    assign best_flow_next = take ? {OFS_W'(s4_idx_reg), s4_x} : flow_base;

    assign push = adv && s4_valid_reg && s4_last;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (push)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg  <= SUM_RESET;
            best_flow_reg <= FLOW_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (adv && s4_valid_reg)
            begin
                best_sum_reg  <= best_sum_next;
                best_flow_reg <= best_flow_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_sad_reg  <= best_sum_next[SAD_W-1:0];
            res_flow_reg <= best_flow_next;
        end
    end

    assign results.valid     = res_valid_reg;
    assign results.min_sad   = res_sad_reg;
    assign results.flow_code = res_flow_reg;

    // ---------------- checks ----------------
    `EBMS_ASSERT(a_cnt_wrap, (columns.valid && columns.ready && cnt_reg == CNT_LAST) |=> (cnt_reg == '0), "column count did not wrap at end of event")
    `EBMS_ASSERT(a_res_from_last, $rose(res_valid_reg) |-> $past(s4_valid_reg && s4_last), "result raised without a last column")
    `EBMS_ASSERT_NEVER(a_flow_idle, results.valid && results.flow_code == FLOW_RESET && results.min_sad != SAD_OUT_RESET, "untouched flow code with a real SAD")

endmodule

// ===== tb/event_block_match_sad_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_block_match_sad_tb
// Streams pixel-column events through the SAD block matcher and checks every
// result against an in-bench prediction of the windowed SAD search. Covers
// saturated and identical columns, planted vertical motion, tie-heavy flat
// images, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module event_block_match_sad_tb;
    import ebms_pkg::*;

    localparam int ROWS        = FIELD_W / PIXEL_BITS;
    localparam int IDLE_PCT    = 18;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [PIXEL_BITS-1:0] pixels_t [ROWS];

    typedef struct packed {
        logic [SAD_W-1:0]  sad;
        logic [FLOW_W-1:0] flow;
    } match_t;

    typedef enum int {
        EV_SATURATE,
        EV_MIRROR,
        EV_RANDOM,
        EV_SHIFTED,
        EV_FLAT,
        EV_EXTREME
    } event_kind_t;

    logic clk;
    logic rst_n;

    ebms_col_if cols ();
    ebms_res_if res ();

    event_block_match_sad dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .columns (cols),
        .results (res)
    );

    // search state mirrored from the block
    int           col_pos;
    sum_t         win_sum  [NSHIFT];
    sum_t         col_hist [BLOCK][NSHIFT];
    sum_t         best_sad;
    logic [FLOW_W-1:0] best_code;

    match_t expected_matches[$];

    int  error_count;
    int  columns_sent;
    int  events_sent;
    int  matches_checked;
    int  cycle_count;
    int  hold_left;
    bit  idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_matches.size());
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [PIXEL_BITS-1:0] pixel_of(input column_t col, input int row);
        if (PIXEL_BITS * row >= FIELD_W)
        begin
            return '0;
        end
        return col[PIXEL_BITS*row +: PIXEL_BITS];
    endfunction

    // difference wraps to 5 bits signed, magnitude also kept in 5 bits
    function automatic int pixel_delta(input logic [PIXEL_BITS-1:0] a,
                                       input logic [PIXEL_BITS-1:0] b);
        logic [DIFF_W-1:0] d5;
        int                v;
        d5 = DIFF_W'(a) - DIFF_W'(b);
        v  = d5[DIFF_W-1] ? int'(d5) - 32 : int'(d5);
        if (v < 0)
        begin
            v = -v;
        end
        d5 = v[DIFF_W-1:0];
        return d5[DIFF_W-1] ? int'(d5) - 32 : int'(d5);
    endfunction

    // advance the search by one column; returns 1 when the event completes
    function automatic bit match_step(input column_t ref_col, input column_t tag_col,
                                      output match_t m);
        int   pos;
        int   k;
        int   s;
        int   low_idx;
        sum_t low;
        sum_t col_sum [NSHIFT];
        pos = (col_pos < COLS) ? col_pos : 0;
        k   = pos + 1;
        m   = '0;
        if (pos == 0)
        begin
            win_sum   = '{default: '0};
            best_sad  = SUM_RESET;
            best_code = FLOW_RESET;
        end
        for (int i = 0; i < NSHIFT; i++)
        begin
            s = 0;
            for (int j = 0; j < BLOCK; j++)
            begin
                s += pixel_delta(pixel_of(ref_col, j + SEARCH), pixel_of(tag_col, i + j));
            end
            col_sum[i] = sum_t'(s);
        end
        for (int i = 0; i < NSHIFT; i++)
        begin
            win_sum[i] = win_sum[i] + col_sum[i] - ((k > BLOCK) ? col_hist[0][i] : sum_t'(0));
        end
        low     = win_sum[0];
        low_idx = 0;
        for (int i = 1; i < NSHIFT; i++)
        begin
            if ($signed(win_sum[i]) < $signed(low))
            begin
                low     = win_sum[i];
                low_idx = i;
            end
        end
        if (k >= BLOCK && $signed(low) < $signed(best_sad))
        begin
            best_sad  = low;
            best_code = {OFS_W'(low_idx), OFS_W'(k - BLOCK)};
        end
        for (int j = 0; j < BLOCK - 1; j++)
        begin
            col_hist[j] = col_hist[j+1];
        end
        col_hist[BLOCK-1] = col_sum;
        if (k >= COLS)
        begin
            col_pos = 0;
            m.sad   = best_sad[SAD_W-1:0];
            m.flow  = best_code;
            return 1'b1;
        end
        col_pos = k;
        return 1'b0;
    endfunction

    function automatic column_t pack_column(input pixels_t px);
        column_t c;
        c = '0;
        for (int l = 0; l < ROWS; l++)
        begin
            c[PIXEL_BITS*l +: PIXEL_BITS] = px[l];
        end
        return c;
    endfunction

    // drives at the falling edge, takes the transaction at the rising edge
    task automatic send_column(input column_t ref_col, input column_t tag_col);
        match_t m;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            cols.valid <= 1'b0;
            @(negedge clk);
        end
        cols.valid      <= 1'b1;
        cols.ref_column <= ref_col;
        cols.tag_column <= tag_col;
        @(posedge clk);
        while (!cols.ready)
        begin
            @(posedge clk);
        end
        columns_sent++;
        if (match_step(ref_col, tag_col, m))
        begin
            expected_matches.push_back(m);
        end
    endtask

    task automatic send_event(input event_kind_t kind);
        pixels_t ref_px;
        pixels_t tag_px;
        int      motion;
        motion = $urandom_range(NSHIFT - 1);
        for (int c = 0; c < COLS; c++)
        begin
            for (int l = 0; l < ROWS; l++)
            begin
                case (kind)
                    EV_SATURATE:
                    begin
                        ref_px[l] = '1;
                        tag_px[l] = '0;
                    end
                    EV_FLAT:
                    begin
                        ref_px[l] = PIXEL_BITS'($urandom_range(1));
                        tag_px[l] = PIXEL_BITS'($urandom_range(1));
                    end
                    EV_EXTREME:
                    begin
                        ref_px[l] = $urandom_range(1) ? '1 : '0;
                        tag_px[l] = $urandom_range(1) ? '1 : '0;
                    end
                    default:
                    begin
                        ref_px[l] = PIXEL_BITS'($urandom());
                        tag_px[l] = PIXEL_BITS'($urandom());
                    end
                endcase
            end
            if (kind == EV_MIRROR)
            begin
                tag_px = ref_px;
            end
            else if (kind == EV_SHIFTED)
            begin
                // plant the reference block at the event's vertical shift, lightly noised
                for (int j = 0; j < BLOCK; j++)
                begin
                    tag_px[motion + j] = ($urandom_range(7) == 0) ?
                                         PIXEL_BITS'($urandom()) : ref_px[SEARCH + j];
                end
            end
            if (kind == EV_RANDOM)
            begin
                send_column(column_t'({$urandom(), $urandom()}),
                            column_t'({$urandom(), $urandom()}));
            end
            else
            begin
                send_column(pack_column(ref_px), pack_column(tag_px));
            end
        end
        events_sent++;
    endtask

    task automatic send_random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            send_event(EV_SHIFTED);
        end
        else if (pick < 75)
        begin
            send_event(EV_RANDOM);
        end
        else if (pick < 90)
        begin
            send_event(EV_FLAT);
        end
        else
        begin
            send_event(EV_EXTREME);
        end
    endtask

    // receiver: random idling, plus a long hold-off when asked
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                res.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial
    begin
        match_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    report_mismatch("unexpected result, sad", res.min_sad, -1);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    matches_checked++;
                    if (res.min_sad !== want.sad)
                    begin
                        report_mismatch("min_sad", res.min_sad, want.sad);
                    end
                    if (res.flow_code !== want.flow)
                    begin
                        report_mismatch("flow_code", res.flow_code, want.flow);
                    end
                end
            end
        end
    end

    // full-scale differences everywhere: all shifts tie, first one wins
    task automatic test_saturated_event();
        send_event(EV_SATURATE);
    endtask

    // tag equals ref: zero SAD at the centered shift, earliest offset kept
    task automatic test_identical_event();
        send_event(EV_MIRROR);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int e = 0; e < 10; e++)
        begin
            send_random_event();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        idle_on   = 1'b0;
        hold_left = 400;
        for (int e = 0; e < 6; e++)
        begin
            send_random_event();
        end
        while (hold_left > 0)
        begin
            @(posedge clk);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_events();
        for (int e = 0; e < 80; e++)
        begin
            send_random_event();
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cols.valid      = 1'b0;
        cols.ref_column = '0;
        cols.tag_column = '0;
        col_pos         = 0;
        win_sum         = '{default: '0};
        col_hist        = '{default: '{default: '0}};
        best_sad        = SUM_RESET;
        best_code       = FLOW_RESET;
        error_count     = 0;
        columns_sent    = 0;
        events_sent     = 0;
        matches_checked = 0;
        cycle_count     = 0;
        hold_left       = 0;
        idle_on         = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_saturated_event();
        test_identical_event();
        test_back_to_back();
        test_output_stall();
        test_random_events();

        @(negedge clk);
        cols.valid <= 1'b0;
        while (expected_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d columns in %0d events, checked %0d results, %0d mismatches",
                 columns_sent, events_sent, matches_checked, error_count);
        $display("events: saturated, identical, planted motion, flat, extreme, random");
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
